@@ sv/rdc_pkg.sv @@
// ----------------------------------------------------------------------------
// rdc_pkg: shared types and constants of the radix digit converter
// Holds the microcode control word, the jump conditions and the program table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rdc_pkg;

  localparam int unsigned ValueWidthDef = 32;
  localparam int unsigned MaxDigitsDef  = 32;
  localparam int unsigned InDataW       = 32;
  localparam int unsigned OutDataW      = 16;
  localparam int unsigned RadixW        = 6;
  localparam int unsigned DigitW        = 6;
  localparam int unsigned IndexW        = 5;
  localparam int unsigned UpcW          = 3;

  localparam logic [RadixW-1:0] RadixReset = 6'd2;
  localparam logic [RadixW-1:0] RadixMin   = 6'd2;
  localparam logic [RadixW-1:0] RadixMax   = 6'd36;

  typedef enum logic [UpcW-1:0] {
    STEP_LOAD   = 3'd0,
    STEP_DIV    = 3'd1,
    STEP_STORE  = 3'd2,
    STEP_RDINIT = 3'd3,
    STEP_READ   = 3'd4,
    STEP_PUT    = 3'd5,
    STEP_ADV    = 3'd6,
    STEP_DONE   = 3'd7
  } step_e;

  typedef enum logic [2:0] {
    COND_NEVER    = 3'd0,
    COND_NO_IN    = 3'd1,
    COND_BIT_MORE = 3'd2,
    COND_DIG_MORE = 3'd3,
    COND_OUT_BUSY = 3'd4,
    COND_RD_MORE  = 3'd5,
    COND_ALWAYS   = 3'd6
  } cond_e;

  typedef struct packed {
    logic  in_rdy;
    logic  q_load;
    logic  div_init;
    logic  div_step;
    logic  dig_wr;
    logic  rd_init;
    logic  rd_en;
    logic  out_put;
    logic  rd_adv;
    cond_e cond;
    step_e target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic bit_more;
    logic dig_more;
    logic out_busy;
    logic rd_more;
  } status_t;

  function automatic ctrl_t ucode(step_e step);
    ctrl_t cw;
    cw = '{in_rdy: 1'b0, q_load: 1'b0, div_init: 1'b0, div_step: 1'b0, dig_wr: 1'b0,
           rd_init: 1'b0, rd_en: 1'b0, out_put: 1'b0, rd_adv: 1'b0,
           cond: COND_NEVER, target: STEP_LOAD};
    unique case (step)
      STEP_LOAD: begin
        cw.in_rdy   = 1'b1;
        cw.q_load   = 1'b1;
        cw.div_init = 1'b1;
        cw.cond     = COND_NO_IN;
        cw.target   = STEP_LOAD;
      end
      STEP_DIV: begin
        cw.div_step = 1'b1;
        cw.cond     = COND_BIT_MORE;
        cw.target   = STEP_DIV;
      end
      STEP_STORE: begin
        cw.dig_wr   = 1'b1;
        cw.div_init = 1'b1;
        cw.cond     = COND_DIG_MORE;
        cw.target   = STEP_DIV;
      end
      STEP_RDINIT: begin
        cw.rd_init = 1'b1;
      end
      STEP_READ: begin
        cw.rd_en = 1'b1;
      end
      STEP_PUT: begin
        cw.out_put = 1'b1;
        cw.cond    = COND_OUT_BUSY;
        cw.target  = STEP_PUT;
      end
      STEP_ADV: begin
        cw.rd_adv = 1'b1;
        cw.cond   = COND_RD_MORE;
        cw.target = STEP_READ;
      end
      STEP_DONE: begin
        cw.cond   = COND_ALWAYS;
        cw.target = STEP_LOAD;
      end
      default: begin
        cw.cond   = COND_ALWAYS;
        cw.target = STEP_LOAD;
      end
    endcase
    return cw;
  endfunction

endpackage

@@ sv/rdc_sequencer.sv @@
// ----------------------------------------------------------------------------
// rdc_sequencer: microprogram counter of the radix digit converter
// Fetches the control word of the current step and evaluates its jump.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rdc_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rdc_pkg::status_t status_i,
  output rdc_pkg::ctrl_t   ctrl_o
);
  import rdc_pkg::*;

  step_e upc_q, upc_d;
  ctrl_t cw;
  logic  take;

  assign cw     = ucode(upc_q);
  assign ctrl_o = cw;

  always_comb begin
    unique case (cw.cond)
      COND_NEVER:    take = 1'b0;
      COND_NO_IN:    take = !status_i.in_valid;
      COND_BIT_MORE: take = status_i.bit_more;
      COND_DIG_MORE: take = status_i.dig_more;
      COND_OUT_BUSY: take = status_i.out_busy;
      COND_RD_MORE:  take = status_i.rd_more;
      COND_ALWAYS:   take = 1'b1;
      default:       take = 1'b1;
    endcase
  end

  always_comb begin
    if (take) begin
      upc_d = cw.target;
    end else begin
      upc_d = step_e'(UpcW'(upc_q + 1'b1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= STEP_LOAD;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

@@ sv/rdc_datapath.sv @@
// ----------------------------------------------------------------------------
// rdc_datapath: divider, digit store and output register
// Runs one restoring division bit per cycle and stores each remainder digit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rdc_datapath #(
  parameter int unsigned VALUE_WIDTH = rdc_pkg::ValueWidthDef,
  parameter int unsigned MAX_DIGITS  = rdc_pkg::MaxDigitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rdc_pkg::ctrl_t               ctrl_i,
  output rdc_pkg::status_t             status_o,
  input  logic                         cfg_we_i,
  input  logic [rdc_pkg::RadixW-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  input  logic [rdc_pkg::InDataW-1:0]  in_value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [rdc_pkg::DigitW-1:0]   out_digit_o,
  output logic [rdc_pkg::IndexW-1:0]   out_index_o,
  output logic                         out_last_o
);
  import rdc_pkg::*;

  localparam int unsigned CopyW = (VALUE_WIDTH < InDataW) ? VALUE_WIDTH : InDataW;
  localparam int unsigned BitW  = $clog2(VALUE_WIDTH);
  localparam int unsigned AddrW = $clog2(MAX_DIGITS);
  localparam int unsigned CntW  = $clog2(MAX_DIGITS + 1);

  logic [RadixW-1:0]      radix_q;
  logic [RadixW-1:0]      base;
  logic [VALUE_WIDTH-1:0] value_in;
  logic [VALUE_WIDTH-1:0] q_q;
  logic [DigitW-1:0]      rem_q;
  logic [BitW-1:0]        bit_q;
  logic [CntW-1:0]        n_q;
  logic [CntW-1:0]        n_dec;
  logic [AddrW-1:0]       ptr_q;
  logic [IndexW-1:0]      k_q;
  logic [DigitW:0]        rem_sh;
  logic                   fits;
  logic [DigitW-1:0]      rem_next;
  logic [DigitW-1:0]      store_mem [MAX_DIGITS];
  logic [DigitW-1:0]      rdata_q;
  logic                   out_valid_q;
  logic [DigitW-1:0]      out_digit_q;
  logic [IndexW-1:0]      out_index_q;
  logic                   out_last_q;
  logic                   out_busy;
  logic                   put_fire;
  logic                   load_fire;

  always_comb begin
    if (radix_q < RadixMin) begin
      base = RadixMin;
    end else if (radix_q > RadixMax) begin
      base = RadixMax;
    end else begin
      base = radix_q;
    end
  end

  always_comb begin
    value_in            = '0;
    value_in[CopyW-1:0] = in_value_i[CopyW-1:0];
  end

  assign rem_sh   = {rem_q, q_q[VALUE_WIDTH-1]};
  assign fits     = rem_sh >= {1'b0, base};
  assign rem_next = fits ? DigitW'(rem_sh - {1'b0, base}) : rem_sh[DigitW-1:0];
  assign n_dec    = n_q - CntW'(1);

  assign out_busy  = out_valid_q && !out_ready_i;
  assign put_fire  = ctrl_i.out_put && !out_busy;
  assign load_fire = ctrl_i.q_load && in_valid_i;

  assign status_o.in_valid = in_valid_i;
  assign status_o.bit_more = bit_q != '0;
  assign status_o.dig_more = (q_q != '0) && (n_q != CntW'(MAX_DIGITS - 1));
  assign status_o.out_busy = out_busy;
  assign status_o.rd_more  = ptr_q != '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q     <= RadixReset;
      q_q         <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        radix_q <= cfg_data_i;
      end
      if (load_fire) begin
        q_q <= value_in;
        n_q <= '0;
      end else if (ctrl_i.div_step) begin
        q_q <= {q_q[VALUE_WIDTH-2:0], fits};
      end else if (ctrl_i.dig_wr) begin
        n_q <= n_q + CntW'(1);
      end
      if (put_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_init) begin
      rem_q <= '0;
      bit_q <= BitW'(VALUE_WIDTH - 1);
    end else if (ctrl_i.div_step) begin
      rem_q <= rem_next;
      bit_q <= bit_q - BitW'(1);
    end
    if (ctrl_i.rd_init) begin
      ptr_q <= n_dec[AddrW-1:0];
      k_q   <= '0;
    end else if (ctrl_i.rd_adv) begin
      ptr_q <= ptr_q - AddrW'(1);
      k_q   <= k_q + IndexW'(1);
    end
    if (put_fire) begin
      out_digit_q <= rdata_q;
      out_index_q <= k_q;
      out_last_q  <= ptr_q == '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.dig_wr) begin
      store_mem[n_q[AddrW-1:0]] <= rem_q;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= store_mem[ptr_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_digit_o = out_digit_q;
  assign out_index_o = out_index_q;
  assign out_last_o  = out_last_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CntW'(MAX_DIGITS))
    else $error("digit count exceeds the digit store depth");

  a_put_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    put_fire |-> !(out_valid_q && !out_ready_i))
    else $error("output register overwritten while a transfer is pending");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    put_fire && (ptr_q == '0) |-> k_q == n_dec[IndexW-1:0])
    else $error("final digit index does not match the digit count");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.dig_wr |-> rem_q < base)
    else $error("stored remainder is not below the base");
`endif

endmodule

@@ sv/radix_digit_converter.sv @@
// ----------------------------------------------------------------------------
// radix_digit_converter: unsigned integer to base 2..36 digit stream
// Takes no new value until all D digits of the last one, at most MAX_DIGITS,
// have gone to the output register; the divider is bit-serial.
// Reset clears the radix to 2 and the sequencer; the digit store is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module radix_digit_converter #(
  parameter int unsigned VALUE_WIDTH = rdc_pkg::ValueWidthDef,
  parameter int unsigned MAX_DIGITS  = rdc_pkg::MaxDigitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rdc_pkg::RadixW-1:0]    cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // Fields from bit 0: value[31:0].
  input  logic [rdc_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // Fields from bit 0: digit[5:0], digit_index[10:6], zero fill[15:11].
  output logic [rdc_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast
);
  import rdc_pkg::*;

  ctrl_t               ctrl;
  status_t             status;
  logic [DigitW-1:0]   digit;
  logic [IndexW-1:0]   digit_index;

  rdc_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  rdc_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_DIGITS  (MAX_DIGITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_value_i  (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_digit_o (digit),
    .out_index_o (digit_index),
    .out_last_o  (m_axis_tlast)
  );

  assign s_axis_tready = ctrl.in_rdy;
  assign m_axis_tdata  = {(OutDataW - DigitW - IndexW)'(0), digit_index, digit};

endmodule
